FILE: design/oft_pkg.sv
// Shared types and constants for the open-file table.
`timescale 1ns / 1ps
`default_nettype none

package oft_pkg;

   localparam int CMD_W   = 3;
   localparam int SLOT_W  = 6;
   localparam int INODE_W = 16;
   localparam int PROT_W  = 8;
   localparam int POS_W   = 32;

   typedef enum logic [CMD_W-1:0] {
      OP_PUT    = 3'd0,
      OP_GET    = 3'd1,
      OP_SETPOS = 3'd2,
      OP_REMOVE = 3'd3,
      OP_EXIST  = 3'd4
   } oft_op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_BADFD = 2'd3
   } oft_status_type;

   typedef struct packed {
      logic [INODE_W-1:0] inode;
      logic [PROT_W-1:0]  prot;
      logic [POS_W-1:0]   pos;
   } oft_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic           clr_step;
      logic           latch;
      logic           put_wr;
      logic           scan_init;
      logic           scan_step;
      logic           scan_fin;
      logic           rd_slot;
      logic           exec;
      logic           reply;
      oft_status_type reply_status;
   } oft_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       clr_last;
      logic       full;
      logic       bad_slot;
      logic       scan_done;
      oft_op_type op;
   } oft_sts_type;

endpackage

`default_nettype wire

FILE: design/oft_ctrl.sv
// Sequencing state machine for the open-file table.
`timescale 1ns / 1ps
`default_nettype none

module oft_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire oft_pkg::oft_sts_type sts,
   output oft_pkg::oft_ctl_type     ctl
);
   import oft_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_DECODE = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_SCAN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.reply_status = STS_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.op)
               OP_PUT: begin
                  if (sts.full) begin
                     ctl.reply        = 1'b1;
                     ctl.reply_status = STS_FULL;
                     state_in         = ST_IDLE;
                  end else begin
                     ctl.put_wr    = 1'b1;
                     ctl.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               OP_GET, OP_SETPOS, OP_REMOVE: begin
                  if (sts.bad_slot) begin
                     ctl.reply        = 1'b1;
                     ctl.reply_status = STS_BADFD;
                     state_in         = ST_IDLE;
                  end else begin
                     ctl.rd_slot = 1'b1;
                     state_in    = ST_CHECK;
                  end
               end
               OP_EXIST: begin
                  ctl.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
               default: begin
                  // unused opcode: all-zero response
                  ctl.reply = 1'b1;
                  state_in  = ST_IDLE;
               end
            endcase
         end
         ST_CHECK: begin
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) begin
               ctl.scan_fin = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/oft_dpath.sv
// Slot memories, allocation head, scan engine and response registers.
`timescale 1ns / 1ps
`default_nettype none

module oft_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire oft_pkg::oft_ctl_type         ctl,
   output oft_pkg::oft_sts_type              sts,
   input  wire logic [oft_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [oft_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [oft_pkg::INODE_W-1:0]  req_inode_in,
   input  wire logic [oft_pkg::PROT_W-1:0]   req_prot_in,
   input  wire logic [oft_pkg::POS_W-1:0]    req_pos_in,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [oft_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [oft_pkg::INODE_W-1:0]       rsp_inode_out,
   output logic [oft_pkg::PROT_W-1:0]        rsp_prot_out,
   output logic [oft_pkg::POS_W-1:0]         rsp_pos_out,
   output logic                              rsp_found
);
   import oft_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int IW = AW + 1;
   localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);
   localparam logic [AW-1:0] LAST_I  = AW'(DEPTH - 1);

   // storage
   logic          valid_mem [DEPTH];
   oft_entry_type entry_mem [DEPTH];
   logic          valid_rd_ff;
   oft_entry_type entry_rd_ff;

   // latched request
   oft_op_type         op_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [INODE_W-1:0] inode_ff;
   logic [PROT_W-1:0]  prot_ff;
   logic [POS_W-1:0]   pos_ff;

   // control state
   logic [IW-1:0] head_ff, head_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic          pend_ff, pend_in;

   // responses
   logic                rsp_strobe_ff, rsp_strobe_in;
   oft_status_type      rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [INODE_W-1:0]  rsp_inode_ff, rsp_inode_in;
   logic [PROT_W-1:0]   rsp_prot_ff, rsp_prot_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_found_ff, rsp_found_in;

   logic          slot_ok;
   logic [AW-1:0] slot_idx;
   logic [IW-1:0] slot_ext;
   logic [AW-1:0] head_idx;
   logic          issue;
   logic          match;
   logic          hit;
   logic          vwe, vwd;
   logic [AW-1:0] vwa;
   logic          ewe;
   logic [AW-1:0] ewa;
   oft_entry_type ewd;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign slot_ok  = 32'(slot_ff) < 32'(DEPTH);
   assign slot_idx = AW'(slot_ff);
   assign slot_ext = IW'(slot_ff);
   assign head_idx = head_ff[AW-1:0];

   // scan engine: one read issued per cycle, its result checked in the cycle after
   assign issue = ctl.scan_step && (rd_idx_ff < DEPTH_I);
   assign match = (op_ff == OP_EXIST) ? (valid_rd_ff && (entry_rd_ff.inode == inode_ff))
                                      : !valid_rd_ff;
   assign hit   = pend_ff && match;

   assign sts.clr_last  = (clr_idx_ff == LAST_I);
   assign sts.full      = (head_ff >= DEPTH_I);
   assign sts.bad_slot  = !slot_ok;
   assign sts.scan_done = hit || (!pend_ff && (rd_idx_ff >= DEPTH_I));
   assign sts.op        = op_ff;

   // memory port muxing
   always_comb begin
      vwe = 1'b0;
      vwa = head_idx;
      vwd = 1'b1;
      if (ctl.clr_step) begin
         vwe = 1'b1;
         vwa = clr_idx_ff;
         vwd = 1'b0;
      end else if (ctl.put_wr) begin
         vwe = 1'b1;
      end else if (ctl.exec && (op_ff == OP_REMOVE) && valid_rd_ff) begin
         vwe = 1'b1;
         vwa = slot_idx;
         vwd = 1'b0;
      end

      ewe = 1'b0;
      ewa = head_idx;
      ewd = '{inode: inode_ff, prot: prot_ff, pos: '0};
      if (ctl.exec && (op_ff == OP_SETPOS) && valid_rd_ff) begin
         ewe = 1'b1;
         ewa = slot_idx;
         ewd = '{inode: entry_rd_ff.inode, prot: entry_rd_ff.prot, pos: pos_ff};
      end else if (ctl.put_wr) begin
         ewe = 1'b1;
      end

      rd_en   = ctl.rd_slot || issue;
      rd_addr = issue ? rd_idx_ff[AW-1:0] : slot_idx;
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         valid_mem[vwa] <= vwd;
      end
      if (rd_en) begin
         valid_rd_ff <= valid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ewe) begin
         entry_mem[ewa] <= ewd;
      end
      if (rd_en) begin
         entry_rd_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         op_ff    <= oft_op_type'(req_cmd);
         slot_ff  <= req_slot;
         inode_ff <= req_inode_in;
         prot_ff  <= req_prot_in;
         pos_ff   <= req_pos_in;
      end
   end

   // head, clear sweep, scan pointers
   always_comb begin
      head_in    = head_ff;
      clr_idx_in = clr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      pidx_in    = pidx_ff;
      pend_in    = pend_ff;

      if (ctl.clr_step) begin
         clr_idx_in = clr_idx_ff + AW'(1);
      end

      if (ctl.scan_init) begin
         rd_idx_in = (op_ff == OP_PUT) ? head_ff + IW'(1) : '0;
         pend_in   = 1'b0;
      end else if (ctl.scan_step) begin
         pend_in = issue;
         pidx_in = rd_idx_ff;
         if (issue) begin
            rd_idx_in = rd_idx_ff + IW'(1);
         end
      end

      if (ctl.scan_fin && (op_ff == OP_PUT)) begin
         head_in = hit ? pidx_ff : DEPTH_I;
      end else if (ctl.exec && (op_ff == OP_REMOVE) && valid_rd_ff && (slot_ext < head_ff)) begin
         head_in = slot_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         clr_idx_ff <= '0;
         rd_idx_ff  <= '0;
         pend_ff    <= 1'b0;
      end else begin
         head_ff    <= head_in;
         clr_idx_ff <= clr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
   end

   // response assembly
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_OK;
      rsp_slot_in   = '0;
      rsp_inode_in  = '0;
      rsp_prot_in   = '0;
      rsp_pos_in    = '0;
      rsp_found_in  = 1'b0;
      if (ctl.reply) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = ctl.reply_status;
      end else if (ctl.exec) begin
         rsp_strobe_in = 1'b1;
         if (!valid_rd_ff) begin
            rsp_status_in = STS_EMPTY;
         end else if (op_ff == OP_GET) begin
            rsp_inode_in = entry_rd_ff.inode;
            rsp_prot_in  = entry_rd_ff.prot;
            rsp_pos_in   = entry_rd_ff.pos;
         end
      end else if (ctl.scan_fin) begin
         rsp_strobe_in = 1'b1;
         if (op_ff == OP_PUT) begin
            rsp_slot_in = SLOT_W'(head_ff);
         end else begin
            rsp_status_in = hit ? STS_OK : STS_EMPTY;
            rsp_found_in  = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_inode_ff  <= rsp_inode_in;
      rsp_prot_ff   <= rsp_prot_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_inode_out = rsp_inode_ff;
   assign rsp_prot_out  = rsp_prot_ff;
   assign rsp_pos_out   = rsp_pos_ff;
   assign rsp_found     = rsp_found_ff;

   // checks
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= DEPTH_I)
      else $error("allocation head beyond table");

   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.put_wr |-> (head_ff < DEPTH_I))
      else $error("put written into a full table");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two responses back to back");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_found_ff) |-> (rsp_status_ff == STS_OK))
      else $error("found flagged with error status");

endmodule

`default_nettype wire

FILE: design/open_file_table_top.sv
// Top level of the open-file table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Path from start to rsp_strobe: full/bad-fd/unused codes reply from the decode
// state through the response register; get, set_pos and remove add the check
// state after one registered memory read. Put and exist walk the valid/entry
// memory one slot per cycle through its single read port.
// One command in flight; busy drops in the cycle the response word is shown.
// Reset: synchronous; afterwards busy stays high while the valid memory is
// swept clear, one slot per cycle. The receiver cannot stall.

module open_file_table_top #(
   parameter int DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [oft_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [oft_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [oft_pkg::INODE_W-1:0] req_inode_in,
   input  wire logic [oft_pkg::PROT_W-1:0]  req_prot_in,
   input  wire logic [oft_pkg::POS_W-1:0]   req_pos_in,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [oft_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic [oft_pkg::INODE_W-1:0]      rsp_inode_out,
   output logic [oft_pkg::PROT_W-1:0]       rsp_prot_out,
   output logic [oft_pkg::POS_W-1:0]        rsp_pos_out,
   output logic                             rsp_found
);
   import oft_pkg::*;

   // command bundle from the sequencer, status bundle back from the datapath
   oft_ctl_type ctl;
   oft_sts_type sts;

   // sequencer: clear sweep, decode, slot access, scan
   oft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   // datapath: slot memories, allocation head, scan engine, response word
   oft_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_cmd       (req_cmd),
      .req_slot      (req_slot),
      .req_inode_in  (req_inode_in),
      .req_prot_in   (req_prot_in),
      .req_pos_in    (req_pos_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_slot_out  (rsp_slot_out),
      .rsp_inode_out (rsp_inode_out),
      .rsp_prot_out  (rsp_prot_out),
      .rsp_pos_out   (rsp_pos_out),
      .rsp_found     (rsp_found)
   );

endmodule

`default_nettype wire
